>>> sv/adsr_pkg.sv
// Shared constants, codes, command/status types and a helper of the ADSR envelope generator.
`default_nettype none

package adsr_pkg;

  // Default widths and fixed field widths.
  localparam int GAIN_BITS_DEF  = 16;
  localparam int COUNT_BITS_DEF = 24;
  localparam int PHASE_BITS     = 3;
  localparam int CFG_DATA_BITS  = 32;
  localparam int CFG_ADDR_BITS  = 5;

  // Phase codes.
  localparam logic [PHASE_BITS-1:0] PH_STOP    = 3'd0;
  localparam logic [PHASE_BITS-1:0] PH_ATTACK  = 3'd1;
  localparam logic [PHASE_BITS-1:0] PH_DECAY   = 3'd2;
  localparam logic [PHASE_BITS-1:0] PH_SUSTAIN = 3'd3;
  localparam logic [PHASE_BITS-1:0] PH_NOTEOFF = 3'd4;
  localparam logic [PHASE_BITS-1:0] PH_RELEASE = 3'd5;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_ATTACK_LENGTH  = 3'd0;
  localparam logic [2:0] REG_ATTACK_PEAK    = 3'd1;
  localparam logic [2:0] REG_DECAY_LENGTH   = 3'd2;
  localparam logic [2:0] REG_SUSTAIN_LEVEL  = 3'd3;
  localparam logic [2:0] REG_RELEASE_LENGTH = 3'd4;

  // Transition plan codes, resolved from the phase and the zero-length flags.
  localparam logic [2:0] PLAN_HOLD        = 3'd0;
  localparam logic [2:0] PLAN_DIV_ATTACK  = 3'd1;
  localparam logic [2:0] PLAN_DIV_DECAY   = 3'd2;
  localparam logic [2:0] PLAN_TO_SUSTAIN  = 3'd3;
  localparam logic [2:0] PLAN_DIV_RELEASE = 3'd4;
  localparam logic [2:0] PLAN_TO_STOP     = 3'd5;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic force_phase;
    logic div_start;
    logic xfer;
    logic emit;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cnt_zero;
    logic need_div;
    logic div_busy;
  } dp_stat_t;

  // Resolves the transition chain, including zero-length fall-through.
  function automatic logic [2:0] plan_f(input logic [PHASE_BITS-1:0] ph,
                                        input logic a_zero,
                                        input logic d_zero,
                                        input logic r_zero);
    logic [2:0] p;
    p = PLAN_HOLD;
    unique case (ph)
      PH_STOP: begin
        if (!a_zero) p = PLAN_DIV_ATTACK;
        else if (!d_zero) p = PLAN_DIV_DECAY;
        else p = PLAN_TO_SUSTAIN;
      end
      PH_ATTACK: begin
        if (!d_zero) p = PLAN_DIV_DECAY;
        else p = PLAN_TO_SUSTAIN;
      end
      PH_DECAY:   p = PLAN_TO_SUSTAIN;
      PH_SUSTAIN: p = PLAN_HOLD;
      PH_NOTEOFF: begin
        if (!r_zero) p = PLAN_DIV_RELEASE;
        else p = PLAN_TO_STOP;
      end
      PH_RELEASE: p = PLAN_TO_STOP;
      default:    p = PLAN_HOLD;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

>>> sv/adsr_if.sv
// Valid/ready channel interfaces for the envelope input items and gain results.
`default_nettype none

interface adsr_in_if;
  import adsr_pkg::*;
  logic                  valid;
  logic                  ready;
  logic                  func;
  logic [PHASE_BITS-1:0] new_phase;

  modport source (output valid, output func, output new_phase, input ready);
  modport sink   (input valid, input func, input new_phase, output ready);
endinterface

interface adsr_out_if #(
  parameter int GAIN_BITS = adsr_pkg::GAIN_BITS_DEF
);
  import adsr_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [GAIN_BITS-1:0]  gain;
  logic [PHASE_BITS-1:0] phase;
  logic                  finished;

  modport source (output valid, output gain, output phase, output finished, input ready);
  modport sink   (input valid, input gain, input phase, input finished, output ready);
endinterface

`default_nettype wire

>>> sv/adsr_cfg.sv
// APB-style configuration register file of the envelope generator.
`default_nettype none

module adsr_cfg #(
  parameter int GAIN_BITS  = adsr_pkg::GAIN_BITS_DEF,
  parameter int COUNT_BITS = adsr_pkg::COUNT_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [adsr_pkg::CFG_ADDR_BITS-1:0] paddr,
  input  wire logic [adsr_pkg::CFG_DATA_BITS-1:0] pwdata,
  output logic      [adsr_pkg::CFG_DATA_BITS-1:0] prdata,
  output logic                                    pready,
  output logic      [COUNT_BITS-1:0]              attack_length,
  output logic      [GAIN_BITS-1:0]               attack_peak,
  output logic      [COUNT_BITS-1:0]              decay_length,
  output logic      [GAIN_BITS-1:0]               sustain_level,
  output logic      [COUNT_BITS-1:0]              release_length
);
  import adsr_pkg::*;

  logic [COUNT_BITS-1:0] attack_length_r;
  logic [GAIN_BITS-1:0]  attack_peak_r;
  logic [COUNT_BITS-1:0] decay_length_r;
  logic [GAIN_BITS-1:0]  sustain_level_r;
  logic [COUNT_BITS-1:0] release_length_r;
  logic [2:0]            reg_idx;
  logic                  wr_en;

  assign reg_idx = paddr[CFG_ADDR_BITS-1:2];
  assign wr_en   = psel & penable & pwrite & pready;
  assign pready  = 1'b1;

  // Register writes; values are truncated to the register widths.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_length_r  <= '0;
      attack_peak_r    <= '0;
      decay_length_r   <= '0;
      sustain_level_r  <= '0;
      release_length_r <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_ATTACK_LENGTH:  attack_length_r  <= pwdata[COUNT_BITS-1:0];
        REG_ATTACK_PEAK:    attack_peak_r    <= pwdata[GAIN_BITS-1:0];
        REG_DECAY_LENGTH:   decay_length_r   <= pwdata[COUNT_BITS-1:0];
        REG_SUSTAIN_LEVEL:  sustain_level_r  <= pwdata[GAIN_BITS-1:0];
        REG_RELEASE_LENGTH: release_length_r <= pwdata[COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Read data, zero-extended to the bus width.
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_ATTACK_LENGTH:  prdata[COUNT_BITS-1:0] = attack_length_r;
      REG_ATTACK_PEAK:    prdata[GAIN_BITS-1:0]  = attack_peak_r;
      REG_DECAY_LENGTH:   prdata[COUNT_BITS-1:0] = decay_length_r;
      REG_SUSTAIN_LEVEL:  prdata[GAIN_BITS-1:0]  = sustain_level_r;
      REG_RELEASE_LENGTH: prdata[COUNT_BITS-1:0] = release_length_r;
      default:            prdata = '0;
    endcase
  end

  assign attack_length  = attack_length_r;
  assign attack_peak    = attack_peak_r;
  assign decay_length   = decay_length_r;
  assign sustain_level  = sustain_level_r;
  assign release_length = release_length_r;

endmodule

`default_nettype wire

>>> sv/adsr_div.sv
// Restoring radix-2 serial divider that produces one quotient bit per cycle.
`default_nettype none

module adsr_div #(
  parameter int GAIN_BITS  = adsr_pkg::GAIN_BITS_DEF,
  parameter int COUNT_BITS = adsr_pkg::COUNT_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [GAIN_BITS-1:0]  dividend,
  input  wire logic [COUNT_BITS-1:0] divisor,
  output logic                       busy,
  output logic      [GAIN_BITS-1:0]  quotient
);
  localparam int ITER_BITS = $clog2(GAIN_BITS + 1);

  logic [GAIN_BITS-1:0]  quo_r, quo_nxt;
  logic [COUNT_BITS-1:0] rem_r, rem_nxt;
  logic [COUNT_BITS-1:0] dsr_r;
  logic [ITER_BITS-1:0]  iter_r, iter_nxt;
  logic                  busy_r, busy_nxt;
  logic [COUNT_BITS:0]   trial;

  // One shift-and-subtract step; the dividend shifts out as quotient bits shift in.
  always_comb begin
    trial    = {rem_r, quo_r[GAIN_BITS-1]};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    iter_nxt = iter_r;
    busy_nxt = busy_r;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      iter_nxt = ITER_BITS'(GAIN_BITS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = COUNT_BITS'(trial - {1'b0, dsr_r});
        quo_nxt = {quo_r[GAIN_BITS-2:0], 1'b1};
      end else begin
        rem_nxt = trial[COUNT_BITS-1:0];
        quo_nxt = {quo_r[GAIN_BITS-2:0], 1'b0};
      end
      iter_nxt = iter_r - 1'b1;
      busy_nxt = (iter_r != ITER_BITS'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      iter_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      iter_r <= iter_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dsr_r <= divisor;
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

>>> sv/adsr_dpath.sv
// Envelope datapath: phase, counter, gain and step registers, divider and result register.
`default_nettype none

module adsr_dpath #(
  parameter int GAIN_BITS  = adsr_pkg::GAIN_BITS_DEF,
  parameter int COUNT_BITS = adsr_pkg::COUNT_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire adsr_pkg::ctrl_cmd_t                  cmd,
  output adsr_pkg::dp_stat_t                        stat,
  input  wire logic      [adsr_pkg::PHASE_BITS-1:0] new_phase,
  input  wire logic      [COUNT_BITS-1:0]           attack_length,
  input  wire logic      [GAIN_BITS-1:0]            attack_peak,
  input  wire logic      [COUNT_BITS-1:0]           decay_length,
  input  wire logic      [GAIN_BITS-1:0]            sustain_level,
  input  wire logic      [COUNT_BITS-1:0]           release_length,
  output logic           [GAIN_BITS-1:0]            out_gain,
  output logic           [adsr_pkg::PHASE_BITS-1:0] out_phase,
  output logic                                      out_finished
);
  import adsr_pkg::*;

  logic [PHASE_BITS-1:0]       phase_r;
  logic [COUNT_BITS-1:0]       count_r;
  logic [GAIN_BITS-1:0]        gain_r;
  logic signed [GAIN_BITS:0]   step_r;
  logic                        fin_r;
  logic [GAIN_BITS-1:0]        out_gain_r;
  logic [PHASE_BITS-1:0]       out_phase_r;
  logic                        out_fin_r;

  logic [2:0]                  plan;
  logic [GAIN_BITS-1:0]        div_a;
  logic [COUNT_BITS-1:0]       div_b;
  logic                        div_busy;
  logic [GAIN_BITS-1:0]        quo;
  logic signed [GAIN_BITS:0]   quo_pos;
  logic signed [GAIN_BITS+1:0] sum;
  logic [GAIN_BITS-1:0]        gain_sat;

  assign plan = plan_f(phase_r, attack_length == '0, decay_length == '0,
                       release_length == '0);

  // Divider operands follow the planned transition.
  always_comb begin
    div_a = gain_r;
    div_b = release_length;
    unique case (plan)
      PLAN_DIV_ATTACK: begin
        div_a = attack_peak;
        div_b = attack_length;
      end
      PLAN_DIV_DECAY: begin
        div_a = (attack_peak > sustain_level) ? attack_peak - sustain_level
                                              : sustain_level - attack_peak;
        div_b = decay_length;
      end
      default: begin
        div_a = gain_r;
        div_b = release_length;
      end
    endcase
  end

  adsr_div #(
    .GAIN_BITS  (GAIN_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .busy     (div_busy),
    .quotient (quo)
  );

  assign quo_pos = $signed({1'b0, quo});

  // Next gain with saturation to the unsigned gain range.
  always_comb begin
    sum = $signed({2'b00, gain_r}) + $signed({step_r[GAIN_BITS], step_r});
    if (sum[GAIN_BITS+1]) gain_sat = '0;
    else if (sum[GAIN_BITS]) gain_sat = '1;
    else gain_sat = sum[GAIN_BITS-1:0];
  end

  // Envelope state: forced phase, transitions and per-sample update.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_STOP;
      count_r <= '0;
      gain_r  <= '0;
      step_r  <= '0;
      fin_r   <= 1'b0;
    end else begin
      if (cmd.force_phase) begin
        if (new_phase <= PH_RELEASE) begin
          phase_r <= new_phase;
          count_r <= '0;
        end
      end
      if (cmd.xfer) begin
        fin_r <= (plan == PLAN_TO_STOP);
        unique case (plan)
          PLAN_DIV_ATTACK: begin
            step_r  <= quo_pos;
            count_r <= attack_length;
            phase_r <= PH_ATTACK;
          end
          PLAN_DIV_DECAY: begin
            gain_r  <= attack_peak;
            count_r <= decay_length;
            step_r  <= (attack_peak > sustain_level) ? -quo_pos : quo_pos;
            phase_r <= PH_DECAY;
          end
          PLAN_TO_SUSTAIN: begin
            phase_r <= PH_SUSTAIN;
            gain_r  <= sustain_level;
            step_r  <= '0;
          end
          PLAN_DIV_RELEASE: begin
            step_r  <= -quo_pos;
            count_r <= release_length;
            phase_r <= PH_RELEASE;
          end
          PLAN_TO_STOP: begin
            phase_r <= PH_STOP;
            gain_r  <= '0;
          end
          default: ;
        endcase
      end
      if (cmd.emit) begin
        fin_r <= 1'b0;
        if (!fin_r) begin
          gain_r <= gain_sat;
          if (count_r != '0) count_r <= count_r - 1'b1;
        end
      end
    end
  end

  // Result register, loaded when the sample is emitted.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_gain_r  <= gain_r;
      out_phase_r <= phase_r;
      out_fin_r   <= fin_r;
    end
  end

  assign stat.cnt_zero = (count_r == '0);
  assign stat.need_div = (plan == PLAN_DIV_ATTACK) || (plan == PLAN_DIV_DECAY) ||
                         (plan == PLAN_DIV_RELEASE);
  assign stat.div_busy = div_busy;

  assign out_gain     = out_gain_r;
  assign out_phase    = out_phase_r;
  assign out_finished = out_fin_r;

endmodule

`default_nettype wire

>>> sv/adsr_ctrl.sv
// Envelope controller: sequences accept, divide, transition and emit, and owns the output valid.
`default_nettype none

module adsr_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_func,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire adsr_pkg::dp_stat_t stat,
  output adsr_pkg::ctrl_cmd_t     cmd
);
  import adsr_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_XFER = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       in_fire;
  logic       slot_free;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid & in_ready;
  assign slot_free = !out_valid_r || out_ready;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_func) begin
            cmd.force_phase = 1'b1;
          end else if (stat.cnt_zero) begin
            if (stat.need_div) begin
              cmd.div_start = 1'b1;
              state_nxt     = S_DIV;
            end else begin
              state_nxt = S_XFER;
            end
          end else begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_DIV: begin
        if (!stat.div_busy) state_nxt = S_XFER;
      end
      S_XFER: begin
        cmd.xfer  = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (slot_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output valid: set by an emit, cleared when the result transaction completes.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

>>> sv/adsr_envelope_generator.sv
// Linear ADSR envelope generator: top level joining registers, controller and datapath.
//
// Input channel in_ch carries items: func 0 is a sample tick, func 1 forces
// the phase to new_phase (codes 6 and 7 are ignored) and clears the sample
// counter; a force gives no result. Each tick gives exactly one result on
// out_ch: the gain for the sample, the phase after the step, and finished,
// which is set with gain 0 and phase stop when the release has just ended.
// The user must write lengths and gains on the APB-style cfg_ port only
// while idle; the block itself does not enforce this.
//
// A force item is done on acceptance. A tick with a running counter goes
// to the emit step, and its result is registered there. A tick that changes
// phase with a ramp step runs the serial divider, one quotient bit per cycle,
// then the transfer and emit steps; other phase changes run the transfer
// and emit steps only.
// The result register holds one result; the next item is accepted while it
// waits, and a tick stalls in its emit step until that result is taken.
// Reset clears the configuration and envelope state, sets the phase to stop
// and drives out_ch.valid low.
`default_nettype none

module adsr_envelope_generator #(
  parameter int GAIN_BITS  = adsr_pkg::GAIN_BITS_DEF,
  parameter int COUNT_BITS = adsr_pkg::COUNT_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  adsr_in_if.sink                                 in_ch,
  adsr_out_if.source                              out_ch,
  input  wire logic                               cfg_psel,
  input  wire logic                               cfg_penable,
  input  wire logic                               cfg_pwrite,
  input  wire logic [adsr_pkg::CFG_ADDR_BITS-1:0] cfg_paddr,
  input  wire logic [adsr_pkg::CFG_DATA_BITS-1:0] cfg_pwdata,
  output logic      [adsr_pkg::CFG_DATA_BITS-1:0] cfg_prdata,
  output logic                                    cfg_pready
);
  import adsr_pkg::*;

  logic [COUNT_BITS-1:0] attack_length;
  logic [GAIN_BITS-1:0]  attack_peak;
  logic [COUNT_BITS-1:0] decay_length;
  logic [GAIN_BITS-1:0]  sustain_level;
  logic [COUNT_BITS-1:0] release_length;
  ctrl_cmd_t             cmd;
  dp_stat_t              stat;
  logic                  in_ready;
  logic                  out_valid;
  logic [GAIN_BITS-1:0]  out_gain;
  logic [PHASE_BITS-1:0] out_phase;
  logic                  out_finished;

  // Configuration registers.
  adsr_cfg #(
    .GAIN_BITS  (GAIN_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_cfg (
    .clk            (clk),
    .rst_n          (rst_n),
    .psel           (cfg_psel),
    .penable        (cfg_penable),
    .pwrite         (cfg_pwrite),
    .paddr          (cfg_paddr),
    .pwdata         (cfg_pwdata),
    .prdata         (cfg_prdata),
    .pready         (cfg_pready),
    .attack_length  (attack_length),
    .attack_peak    (attack_peak),
    .decay_length   (decay_length),
    .sustain_level  (sustain_level),
    .release_length (release_length)
  );

  // Sequencing.
  adsr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_func   (in_ch.func),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Envelope arithmetic and state.
  adsr_dpath #(
    .GAIN_BITS  (GAIN_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .new_phase      (in_ch.new_phase),
    .attack_length  (attack_length),
    .attack_peak    (attack_peak),
    .decay_length   (decay_length),
    .sustain_level  (sustain_level),
    .release_length (release_length),
    .out_gain       (out_gain),
    .out_phase      (out_phase),
    .out_finished   (out_finished)
  );

  assign in_ch.ready     = in_ready;
  assign out_ch.valid    = out_valid;
  assign out_ch.gain     = out_gain;
  assign out_ch.phase    = out_phase;
  assign out_ch.finished = out_finished;

endmodule

`default_nettype wire

>>> sv/adsr_checker.sv
// Port-level checker for the envelope generator, bound to the top level.
`default_nettype none

module adsr_checker #(
  parameter int GAIN_BITS = adsr_pkg::GAIN_BITS_DEF
) (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            out_valid,
  input wire logic                            out_ready,
  input wire logic [GAIN_BITS-1:0]            out_gain,
  input wire logic [adsr_pkg::PHASE_BITS-1:0] out_phase,
  input wire logic                            out_finished,
  input wire logic                            cfg_pready
);
  import adsr_pkg::*;

  // A finished result always reports silence in the stop phase.
  a_fin_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_finished) |-> (out_gain == '0 && out_phase == PH_STOP))
    else $error("finished result with nonzero gain or phase other than stop");

  // Reported phases stay within the defined codes.
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_phase <= PH_RELEASE))
    else $error("result phase code out of range");

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_gain) && $stable(out_phase) && $stable(out_finished)))
    else $error("stalled result changed or dropped");

  // The configuration port never inserts wait states.
  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_pready)
    else $error("configuration pready low");

endmodule

bind adsr_envelope_generator adsr_checker #(
  .GAIN_BITS (GAIN_BITS)
) u_adsr_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_gain     (out_ch.gain),
  .out_phase    (out_ch.phase),
  .out_finished (out_ch.finished),
  .cfg_pready   (cfg_pready)
);

`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for the linear ADSR envelope generator with its own gain predictor.
import adsr_pkg::*;

typedef enum logic {
  FUNC_TICK  = 1'b0,
  FUNC_FORCE = 1'b1
} item_func_e;

typedef struct packed {
  logic [15:0] gain;
  logic [2:0]  phase;
  logic        finished;
} gain_result_t;

// Envelope predictor plus the queue of gain samples still owed by the block.
class envelope_scoreboard;
  logic [23:0]        atk_len;
  logic [15:0]        atk_peak;
  logic [23:0]        dec_len;
  logic [15:0]        sus_level;
  logic [23:0]        rel_len;
  logic [2:0]         cur_phase;
  logic [23:0]        count;
  logic [15:0]        gain;
  logic signed [16:0] step;
  gain_result_t       pending[$];
  int unsigned        errors;

  function new();
    atk_len   = '0;
    atk_peak  = '0;
    dec_len   = '0;
    sus_level = '0;
    rel_len   = '0;
    cur_phase = PH_STOP;
    count     = '0;
    gain      = '0;
    step      = '0;
    errors    = 0;
  endfunction

  // Prints one line per mismatch and counts it.
  task report(input string msg);
    $display("MISMATCH: %s", msg);
    errors++;
  endtask

  function void set_register(input logic [2:0] idx, input logic [31:0] value);
    case (idx)
      REG_ATTACK_LENGTH: atk_len = value[23:0];
      REG_ATTACK_PEAK: atk_peak = value[15:0];
      REG_DECAY_LENGTH: dec_len = value[23:0];
      REG_SUSTAIN_LEVEL: sus_level = value[15:0];
      REG_RELEASE_LENGTH: rel_len = value[23:0];
      default: ;
    endcase
  endfunction

  // Phase change at counter zero; zero-length phases fall through.
  // Returns 1 when the release has just ended.
  function bit advance_phase();
    logic [2:0]  p;
    logic [15:0] q;
    p = cur_phase;
    if (p == PH_STOP) begin
      p = PH_ATTACK;
      if (atk_len != 0) begin
        q = 16'(atk_peak / atk_len);
        step = $signed({1'b0, q});
        count = atk_len;
        cur_phase = p;
        return 1'b0;
      end
    end
    if (p == PH_ATTACK) begin
      p = PH_DECAY;
      if (dec_len != 0) begin
        gain = atk_peak;
        count = dec_len;
        if (atk_peak > sus_level) begin
          q = 16'((atk_peak - sus_level) / dec_len);
          step = -$signed({1'b0, q});
        end else begin
          q = 16'((sus_level - atk_peak) / dec_len);
          step = $signed({1'b0, q});
        end
        cur_phase = p;
        return 1'b0;
      end
    end
    if (p == PH_DECAY) begin
      cur_phase = PH_SUSTAIN;
      gain = sus_level;
      step = '0;
      return 1'b0;
    end
    if (p == PH_NOTEOFF) begin
      p = PH_RELEASE;
      if (rel_len != 0) begin
        q = 16'(gain / rel_len);
        step = -$signed({1'b0, q});
        count = rel_len;
        cur_phase = p;
        return 1'b0;
      end
    end
    if (p == PH_RELEASE) begin
      cur_phase = PH_STOP;
      gain = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Updates the envelope for one accepted input transaction.
  function void note_item(input logic f, input logic [2:0] np);
    gain_result_t r;
    int           nxt;
    if (f == FUNC_FORCE) begin
      if (np <= PH_RELEASE) begin
        cur_phase = np;
        count = '0;
      end
      return;
    end
    if (count == 0 && advance_phase()) begin
      r = '{gain: 16'd0, phase: PH_STOP, finished: 1'b1};
      pending.push_back(r);
      return;
    end
    r = '{gain: gain, phase: cur_phase, finished: 1'b0};
    pending.push_back(r);
    // The ramp saturates at both ends of the gain range.
    nxt = int'(gain) + int'(step);
    if (nxt < 0) nxt = 0;
    if (nxt > 65535) nxt = 65535;
    gain = 16'(nxt);
    if (count != 0) count--;
  endfunction

  task check_result(input logic [15:0] g, input logic [2:0] p, input logic fin);
    gain_result_t want;
    if (pending.size() == 0) begin
      report($sformatf("unexpected result gain=%0d phase=%0d finished=%0b", g, p, fin));
      return;
    end
    want = pending.pop_front();
    if (g !== want.gain) begin
      report($sformatf("gain %0d, expected %0d", g, want.gain));
    end
    if (p !== want.phase) begin
      report($sformatf("phase %0d, expected %0d", p, want.phase));
    end
    if (fin !== want.finished) begin
      report($sformatf("finished %0b, expected %0b", fin, want.finished));
    end
  endtask
endclass

module tb;
  logic        clk;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [4:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int unsigned in_gap_max;
  int unsigned out_gap_max;
  int unsigned hold_off;

  envelope_scoreboard sb;

  adsr_in_if in_ch ();
  adsr_out_if #(.GAIN_BITS(16)) out_ch ();

  adsr_envelope_generator u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Writes one register, then reads it back.
  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.set_register(idx, value);
    @(negedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== value) begin
      sb.report($sformatf("register %0d reads %0h, wrote %0h", idx, cfg_prdata, value));
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic apply_settings(input logic [23:0] a_len, input logic [15:0] peak,
                                input logic [23:0] d_len, input logic [15:0] sus,
                                input logic [23:0] r_len);
    cfg_write(REG_ATTACK_LENGTH, {8'd0, a_len});
    cfg_write(REG_ATTACK_PEAK, {16'd0, peak});
    cfg_write(REG_DECAY_LENGTH, {8'd0, d_len});
    cfg_write(REG_SUSTAIN_LEVEL, {16'd0, sus});
    cfg_write(REG_RELEASE_LENGTH, {8'd0, r_len});
  endtask

  // Offers one item after a random gap; returns at the accepting edge with valid still high.
  task automatic send_item(input logic f, input logic [2:0] np);
    int unsigned gap;
    gap = $urandom_range(0, in_gap_max);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.func      <= f;
    in_ch.new_phase <= np;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_item(f, np);
  endtask

  // Stops offering, waits for every owed result, then lets a trailing force settle.
  task automatic drain();
    int unsigned waited;
    waited = 0;
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0 && waited < 5000) begin
      @(negedge clk);
      waited++;
    end
    if (sb.pending.size() != 0) begin
      sb.report($sformatf("%0d results never arrived", sb.pending.size()));
      sb.pending.delete();
    end
    repeat (40) @(negedge clk);
  endtask

  function automatic logic [23:0] pick_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return 24'd0;
    if (r < 15) return 24'hFFFFFF;
    if (r < 20) return 24'($urandom);
    if (r < 60) return 24'($urandom_range(1, 6));
    return 24'($urandom_range(1, 40));
  endfunction

  function automatic logic [15:0] pick_gain();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return 16'd0;
    if (r < 30) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  function automatic int unsigned pick_gap_max();
    int unsigned r;
    r = $urandom_range(0, 3);
    if (r < 2) return (r == 0) ? 0 : 3;
    return 19;
  endfunction

  // Result side: random stalls, with one long hold-off when requested.
  initial begin : result_sink
    int unsigned stall;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    out_ch.ready <= 1'b1;
    forever begin
      do @(posedge clk); while (!out_ch.valid);
      sb.check_result(out_ch.gain, out_ch.phase, out_ch.finished);
      stall = $urandom_range(0, out_gap_max) + hold_off;
      hold_off = 0;
      if (stall > 0) begin
        @(negedge clk);
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Main stimulus: directed walk through the envelope, then random phases.
  initial begin : stimulus
    int unsigned r;
    sb = new();
    in_gap_max      = 0;
    out_gap_max     = 0;
    hold_off        = 0;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.func      = FUNC_TICK;
    in_ch.new_phase = PH_STOP;
    cfg_psel        = 1'b0;
    cfg_penable     = 1'b0;
    cfg_pwrite      = 1'b0;
    cfg_paddr       = '0;
    cfg_pwdata      = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: full attack, decay, sustain, release, restart and forced phases.
    apply_settings(24'd3, 16'hFFFF, 24'd2, 16'd1000, 24'd2);
    in_gap_max  = 3;
    out_gap_max = 19;
    repeat (7) send_item(FUNC_TICK, PH_STOP);
    send_item(FUNC_FORCE, PH_SUSTAIN);
    send_item(FUNC_TICK, 3'd7);
    send_item(FUNC_FORCE, PH_NOTEOFF);
    repeat (4) send_item(FUNC_TICK, PH_STOP);
    send_item(FUNC_FORCE, 3'd6);
    send_item(FUNC_FORCE, 3'd7);
    send_item(FUNC_TICK, PH_RELEASE);
    send_item(FUNC_FORCE, PH_STOP);
    send_item(FUNC_FORCE, PH_ATTACK);
    send_item(FUNC_FORCE, PH_DECAY);
    send_item(FUNC_FORCE, PH_RELEASE);
    repeat (2) send_item(FUNC_TICK, PH_STOP);
    drain();

    // Random phases: the first two use the extreme settings.
    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 0) begin
        apply_settings(24'd0, 16'hFFFF, 24'd0, 16'd0, 24'd0);
      end else if (ph == 1) begin
        apply_settings(24'hFFFFFF, 16'd0, 24'hFFFFFF, 16'hFFFF, 24'hFFFFFF);
      end else begin
        apply_settings(pick_length(), pick_gain(), pick_length(), pick_gain(), pick_length());
      end
      in_gap_max  = pick_gap_max();
      out_gap_max = pick_gap_max();
      if (ph == 2) begin
        in_gap_max = 0;
        hold_off   = 300;
      end
      repeat (88) begin
        r = $urandom_range(0, 99);
        if (r < 82) begin
          send_item(FUNC_TICK, 3'($urandom));
        end else if (r < 88) begin
          send_item(FUNC_FORCE, PH_NOTEOFF);
        end else if (r < 91) begin
          send_item(FUNC_FORCE, PH_STOP);
        end else begin
          send_item(FUNC_FORCE, 3'($urandom_range(0, 7)));
        end
      end
      drain();
    end

    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin : watchdog
    #2000000;
    $display("FAIL");
    $finish;
  end
endmodule
